@@ hw/rtl/b9to17_pkg.sv @@
// ----------------------------------------------------------------------------
// b9to17_pkg
// Types, constants and helper functions shared by the base-9 to base-17
// converter modules.
// ----------------------------------------------------------------------------
package b9to17_pkg;

  // Number of decimal digits of the magnitude read as base-9 digits
  localparam int IN_DIGITS_DEF = 9;

  localparam int MAG_W = 30;
  // Largest value is nine nines in base 9, which needs 29 bits
  localparam int VAL_W = 29;
  // That value needs at most eight base-17 digits
  localparam int MAX_OUT_DIGITS = 8;
  localparam int DIG_IDX_W = 3;
  localparam int DIG_W = 5;
  localparam int CHAR_W = 7;
  localparam int QUEUE_DEPTH = 2;

  // x / 10 == (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP10_SHIFT = 35;
  // x / 17 == (x * RECIP17) >> 33 for any 29-bit x
  localparam logic [28:0] RECIP17 = 29'd505290271;
  localparam int RECIP17_SHIFT = 33;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A = 7'd65;
  localparam logic [DIG_W-1:0] DEC_LIMIT = 5'd10;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             negative;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  // One converted value handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             negative;
  } job_t;

  // Handshake between the front and the queue
  typedef struct packed {
    logic push;
    job_t job;
  } push_req_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_ACC,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

  // Weight of base-9 digit position idx
  function automatic logic [25:0] pow9(input logic [3:0] idx);
    logic [25:0] w;
    unique case (idx)
      4'd0:    w = 26'd1;
      4'd1:    w = 26'd9;
      4'd2:    w = 26'd81;
      4'd3:    w = 26'd729;
      4'd4:    w = 26'd6561;
      4'd5:    w = 26'd59049;
      4'd6:    w = 26'd531441;
      4'd7:    w = 26'd4782969;
      4'd8:    w = 26'd43046721;
      default: w = 26'd0;
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/base9_to_base17_converter.sv @@
// ----------------------------------------------------------------------------
// base9_to_base17_converter
// Reads the decimal digits of a magnitude as base-9 digits and emits the
// value as ASCII base-17 characters, with a leading '-' when negative.
//
//   channel  ports                      handshake
//   input    start, busy, in_data       taken when start && !busy
//   result   out_valid, out_data        one character per strobe, no back-pressure
//
// The front does one reciprocal multiply and one weighted accumulate per
// decimal digit between accepting a word and handing it off to the queue.
// The back pops a number, does one divide-by-17 step per base-17 digit (at
// most 8), then emits one output character per strobe (at most 9).
// A two-entry queue between them lets the front start the next word while
// the back still emits; busy rises only while the front works on a word.
// Reset (rst_n, synchronous) empties the queue and idles both parts.
// ----------------------------------------------------------------------------
module base9_to_base17_converter
  import b9to17_pkg::*;
#(
  parameter int IN_DIGITS = IN_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  push_req_t push_req;
  job_t      head;
  logic      q_full;
  logic      q_empty;
  logic      pop;

  b9to17_front #(
    .IN_DIGITS(IN_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .q_full   (q_full),
    .push_req (push_req)
  );

  b9to17_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  b9to17_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/b9to17_front.sv @@
// ----------------------------------------------------------------------------
// b9to17_front
// Accepts a number and folds its decimal digits, weighted by powers of nine,
// into a binary value, multiplying and accumulating per digit, then queues it.
// ----------------------------------------------------------------------------
module b9to17_front
  import b9to17_pkg::*;
#(
  parameter int IN_DIGITS = IN_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  input  logic      q_full,
  output push_req_t push_req
);

  localparam int CNT_W = (IN_DIGITS > 1) ? $clog2(IN_DIGITS) : 1;

  front_state_t state_r, state_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [MAG_W-4:0] quo_r, quo_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [61:0] prod10;
  logic [MAG_W-1:0] rem_full;
  logic [3:0] dec_digit;
  logic [29:0] term;

  assign prod10 = 62'(mag_r) * 62'(RECIP10);
  assign rem_full = mag_r - {quo_r, 3'b000} - {2'b00, quo_r, 1'b0};
  assign dec_digit = rem_full[3:0];
  assign term = 30'(dec_digit) * 30'(pow9(4'(cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r   <= mag_nxt;
    quo_r   <= quo_nxt;
    value_r <= value_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    quo_nxt   = quo_r;
    value_nxt = value_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    push_req.push = 1'b0;
    push_req.job.value = value_r;
    push_req.job.negative = neg_r;
    unique case (state_r)
      FR_IDLE: begin
        if (start) begin
          mag_nxt   = in_data.magnitude;
          neg_nxt   = in_data.negative;
          value_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = FR_MUL;
        end
      end
      FR_MUL: begin
        quo_nxt   = (MAG_W-3)'(prod10[61:RECIP10_SHIFT]);
        state_nxt = FR_ACC;
      end
      FR_ACC: begin
        value_nxt = value_r + term[VAL_W-1:0];
        mag_nxt   = MAG_W'(quo_r);
        if (cnt_r == CNT_W'(IN_DIGITS - 1)) begin
          state_nxt = FR_PUSH;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = FR_MUL;
        end
      end
      FR_PUSH: begin
        // hold until the queue has room
        if (!q_full) begin
          push_req.push = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  assign busy = (state_r != FR_IDLE);

  a_push_only_in_push: assert property (@(posedge clk) disable iff (!rst_n)
    push_req.push |-> (state_r == FR_PUSH) && !q_full)
    else $error("front pushed outside push state or into full queue");

  a_push_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push_req.push |=> (state_r == FR_IDLE))
    else $error("front did not return to idle after push");

endmodule

@@ hw/rtl/b9to17_queue.sv @@
// ----------------------------------------------------------------------------
// b9to17_queue
// Short register queue of converted values between front and back.
// ----------------------------------------------------------------------------
module b9to17_queue
  import b9to17_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_req_t push_req,
  input  logic      pop,
  output job_t      head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_req.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push_req.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_req.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_req.push) begin
      slot_r[wr_ptr_r] <= push_req.job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_req.push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");

endmodule

@@ hw/rtl/b9to17_back.sv @@
// ----------------------------------------------------------------------------
// b9to17_back
// Takes a value from the queue, splits it into base-17 digits one divide
// step a cycle, then emits sign and digits most significant first.
// ----------------------------------------------------------------------------
module b9to17_back
  import b9to17_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data
);

  back_state_t state_r, state_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic neg_r, neg_nxt;
  logic [DIG_IDX_W-1:0] wi_r, wi_nxt;
  logic [DIG_IDX_W-1:0] ei_r, ei_nxt;
  logic [DIG_W-1:0] dig_r [MAX_OUT_DIGITS];
  logic dig_we;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [57:0] prod17;
  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] rem_full;

  assign prod17 = 58'(val_r) * 58'(RECIP17);
  assign quo = VAL_W'(prod17[57:RECIP17_SHIFT]);
  assign rem_full = val_r - {quo[VAL_W-5:0], 4'b0000} - quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    neg_r      <= neg_nxt;
    wi_r       <= wi_nxt;
    ei_r       <= ei_nxt;
    out_data_r <= out_data_nxt;
    if (dig_we) begin
      dig_r[wi_r] <= rem_full[DIG_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    neg_nxt       = neg_r;
    wi_nxt        = wi_r;
    ei_nxt        = ei_r;
    dig_we        = 1'b0;
    pop           = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          val_nxt = head.value;
          // zero prints a bare '0'
          neg_nxt = head.negative && (head.value != '0);
          wi_nxt  = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        dig_we  = 1'b1;
        val_nxt = quo;
        if (quo == '0) begin
          ei_nxt    = wi_r;
          state_nxt = BK_EMIT;
        end else begin
          wi_nxt = wi_r + 1'b1;
        end
      end
      BK_EMIT: begin
        out_valid_nxt = 1'b1;
        if (neg_r) begin
          out_data_nxt.character = CHAR_MINUS;
          out_data_nxt.last      = 1'b0;
          neg_nxt                = 1'b0;
        end else begin
          out_data_nxt.character = digit_char(dig_r[ei_r]);
          out_data_nxt.last      = (ei_r == '0);
          if (ei_r == '0) begin
            state_nxt = BK_IDLE;
          end else begin
            ei_nxt = ei_r - 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_digit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV && quo != '0) |-> (wi_r != DIG_IDX_W'(MAX_OUT_DIGITS - 1)))
    else $error("base-17 digit buffer overflow");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt |-> (state_r == BK_EMIT))
    else $error("result strobe outside emit state");

endmodule
